### hdl/rppb_pkg.sv
package rppb_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int PKT_W   = 16;
  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 5;
  localparam int WHY_W   = 2;
  localparam int COUNT_W = 6;
  localparam int LIM_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIM_W-1:0]  LIMIT_RESET = 6'd32;
  localparam logic [TIME_W-1:0] AGE_RESET   = 32'd3000;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_SEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP    = 3'd2;
  localparam logic [OP_W-1:0] OP_COLLECT = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  localparam logic [WHY_W-1:0] WHY_FULL    = 2'd0;
  localparam logic [WHY_W-1:0] WHY_AGED    = 2'd1;
  localparam logic [WHY_W-1:0] WHY_NOROUTE = 2'd2;
  localparam logic [WHY_W-1:0] WHY_FLUSH   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] dst_ip;
    logic [PKT_W-1:0]  packet_id;
    logic [TIME_W-1:0] now_ms;
    logic              route_ok;
    logic [ADDR_W-1:0] route_next_hop;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PKT_W-1:0]   out_packet;
    logic [ADDR_W-1:0]  out_next_hop;
    logic [SLOT_W-1:0]  send_slot;
    logic [WHY_W-1:0]   drop_reason;
    logic [COUNT_W-1:0] done_count;
    logic               status;
    logic               last;
  } out_item_t;

endpackage

### hdl/rppb_in_if.sv
interface rppb_in_if import rppb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/rppb_out_if.sv
interface rppb_out_if import rppb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/rppb_cfg_if.sv
interface rppb_cfg_if import rppb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/rppb_ram.sv
module rppb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rppb_ctrl.sv
module rppb_ctrl import rppb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int EW = ADDR_W + HANDLE_BITS + TIME_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rppb_in_if.sink               in_ch,
  rppb_out_if.source            out_ch,
  input  logic [LIM_W-1:0]      queue_limit,
  input  logic [TIME_W-1:0]     max_age_ms,
  output logic                  busy,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [EW-1:0]         ram_wdata,
  output logic [AW-1:0]         ram_raddr,
  input  logic [EW-1:0]         ram_rdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // scan walks read index rd and compacting write index wr over one memory
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        cmd_r, cmd_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   wr_r, wr_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic            status_r, status_nxt;
  logic            append_r, append_nxt;
  logic            ov_r, ov_nxt;
  out_item_t       ob_r, ob_nxt;

  logic [CW-1:0]       lim;
  logic [ADDR_W-1:0]   e_dest;
  logic [HANDLE_BITS-1:0] e_pkt;
  logic [TIME_W-1:0]   e_time;
  logic [TIME_W-1:0]   age;
  logic                hit;
  logic [WHY_W-1:0]    why;
  logic [EW-1:0]       new_entry;
  out_item_t           done_item;

  assign {e_dest, e_pkt, e_time} = ram_rdata;
  assign age = cmd_r.now_ms - e_time;
  assign new_entry = {cmd_r.dst_ip, HANDLE_BITS'(cmd_r.packet_id), cmd_r.now_ms};

  // effective limit clamped to 1 .. depth
  always_comb begin
    if (queue_limit == '0) begin
      lim = CW'(1);
    end else if ({1'b0, queue_limit} > (LIM_W+1)'(QUEUE_DEPTH)) begin
      lim = CW'(QUEUE_DEPTH);
    end else begin
      lim = CW'(queue_limit);
    end
  end

  // match of the entry just read
  always_comb begin
    hit = 1'b0;
    why = WHY_FULL;
    case (cmd_r.opcode)
      OP_ADD: begin
        hit = (rd_r == '0) && ov_r;
        why = WHY_FULL;
      end
      OP_SEND: hit = (e_dest == cmd_r.dst_ip);
      OP_DROP: begin
        hit = (e_dest == cmd_r.dst_ip);
        why = WHY_NOROUTE;
      end
      OP_COLLECT: begin
        hit = (age > max_age_ms);
        why = WHY_AGED;
      end
      OP_FLUSH: begin
        hit = 1'b1;
        why = WHY_FLUSH;
      end
      default: hit = 1'b0;
    endcase
  end

  // done transfer payload from the values the run ends with
  always_comb begin
    done_item            = '0;
    done_item.kind       = KIND_DONE;
    done_item.done_count = cnt_nxt;
    done_item.status     = status_nxt;
    done_item.last       = 1'b1;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_EMIT) || (state_r == S_DONE);
  assign out_ch.data  = ob_r;
  assign busy         = (state_r != S_IDLE);
  assign ram_raddr    = rd_nxt[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    occ_nxt    = occ_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    append_nxt = append_r;
    ov_nxt     = ov_r;
    ob_nxt     = ob_r;
    ram_we     = 1'b0;
    ram_waddr  = wr_r[AW-1:0];
    ram_wdata  = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.data;
          rd_nxt     = '0;
          wr_nxt     = '0;
          cnt_nxt    = '0;
          status_nxt = 1'b0;
          append_nxt = (in_ch.data.opcode == OP_ADD);
          ov_nxt     = (occ_r >= lim) && (occ_r != '0);
          if (in_ch.data.opcode == OP_SEND && !in_ch.data.route_ok) begin
            status_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else if (in_ch.data.opcode > OP_FLUSH || occ_r == '0) begin
            state_nxt  = (in_ch.data.opcode == OP_ADD) ? S_EVAL : S_DONE;
          end else if (in_ch.data.opcode == OP_ADD
                       && !((occ_r >= lim) && (occ_r != '0))) begin
            state_nxt  = S_EVAL;
            rd_nxt     = occ_r;
            wr_nxt     = occ_r;
          end else begin
            state_nxt  = S_READ;
          end
        end
      end
      // memory output for rd is valid in this cycle
      S_READ: begin
        if (rd_r >= occ_r) begin
          state_nxt = S_EVAL;
        end else if (hit) begin
          ob_nxt = '0;
          ob_nxt.kind       = (cmd_r.opcode == OP_SEND) ? KIND_SEND : KIND_DROP;
          ob_nxt.out_packet = PKT_W'(e_pkt);
          if (cmd_r.opcode == OP_SEND) begin
            ob_nxt.out_next_hop = cmd_r.route_next_hop;
            ob_nxt.send_slot    = (cnt_r > COUNT_W'(31)) ? SLOT_W'(31) : cnt_r[SLOT_W-1:0];
          end else begin
            ob_nxt.drop_reason  = why;
          end
          cnt_nxt   = cnt_r + COUNT_W'(1);
          rd_nxt    = rd_r + CW'(1);
          state_nxt = S_EMIT;
        end else begin
          ram_we    = (wr_r != rd_r);
          wr_nxt    = wr_r + CW'(1);
          rd_nxt    = rd_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          state_nxt = (rd_r >= occ_r) ? S_EVAL : S_READ;
        end
      end
      // scan finished: settle occupancy and append for add
      S_EVAL: begin
        occ_nxt = wr_r;
        if (append_r && (wr_r < CW'(QUEUE_DEPTH))) begin
          ram_we    = 1'b1;
          ram_waddr = wr_r[AW-1:0];
          ram_wdata = new_entry;
          occ_nxt   = wr_r + CW'(1);
        end
        append_nxt = 1'b0;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      append_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      append_r <= append_nxt;
    end
  end

  // done payload is loaded on entry to the done state and held there
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    ov_r     <= ov_nxt;
    if (state_nxt == S_DONE && state_r != S_DONE) begin
      ob_r <= done_item;
    end else begin
      ob_r <= ob_nxt;
    end
  end

endmodule

### hdl/route_pending_packet_buffer_unit.sv
// pending-packet buffer for route discovery
// in_ channel: one operation per transfer (add, send, drop, collect, flush);
// in_ready is high only while the block is idle.
// out_ channel: the per-packet results of the operation in buffer order,
// oldest first, then one done transfer with last set and the removed count.
// cfg_ channel: index 0 queue limit, index 1 age limit; write while idle.
// sequence: an operation walks the stored entries through one memory with a
// registered read, checking each entry in turn; each result is shown in its
// own emit state, then a settle step updates occupancy and appends, then the
// done transfer is offered, and the next operation is taken in the idle state.
// an add that needs no eviction skips the walk and goes straight to the
// append; a refused send goes straight to the done transfer.
// the walk rewrites kept entries downward so the buffer stays compacted.
// reset empties the buffer (occupancy zero) and restores the registers;
// memory contents are not cleared and need not be.
// a stalled receiver holds the current result; the walk waits behind it.
module route_pending_packet_buffer_unit import rppb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rppb_in_if.sink    in_ch,
  rppb_out_if.source out_ch,
  rppb_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = ADDR_W + HANDLE_BITS + TIME_W;

  logic [LIM_W-1:0]  queue_limit_r;
  logic [TIME_W-1:0] max_age_r;
  logic              busy;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
      max_age_r     <= AGE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_QUEUE_LIMIT: queue_limit_r <= cfg_ch.wdata[LIM_W-1:0];
        REG_MAX_AGE:     max_age_r     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  rppb_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch,
    .queue_limit(queue_limit_r), .max_age_ms(max_age_r), .busy,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

  rppb_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // no new operation while one is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("ready while busy");

  // done transfer ends a run and frees the input
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.data.last) |=> in_ch.ready)
    else $error("no idle after done");

  // results only while an operation runs
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> busy) else $error("result while idle");

endmodule
